FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/faet_pkg.sv
// types and constants of the feature admit/evict table
// no dependencies
package faet_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_FILTER = 3'd1;
  localparam logic [2:0] OP_RECORD = 3'd2;
  localparam logic [2:0] OP_LOAD_COUNT = 3'd3;
  localparam logic [2:0] OP_LOAD_STAMP = 3'd4;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_FILTER = 2'd1;
  localparam logic [1:0] KIND_EVICT = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  localparam logic [1:0] REG_ADMIT_ENABLE = 2'd0;
  localparam logic [1:0] REG_ADMIT_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_EVICT_AGE = 2'd2;
  localparam logic [1:0] REG_EVICT_INTERVAL = 2'd3;

  localparam logic [39:0] COUNT_MAX = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0] op;
    logic signed [63:0] key;
    logic signed [31:0] count_value;
    logic count_present;
    logic [31:0] stamp;
    logic batch_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [63:0] key_out;
    logic rejected;
    logic last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_READ,
    ST_MOD,
    ST_APPLY,
    ST_SWEEP_RD,
    ST_SWEEP_CHK,
    ST_SWEEP_OUT,
    ST_RETRY,
    ST_EMIT,
    ST_OUT_WAIT
  } state_t;

endpackage

FILE: rtl/core/feature_admit_evict_table.sv
// feature admit/evict table: keyed counts and stamps with periodic age sweeps
// depends on faet_pkg and assert_macros.svh
//
// channel  | signals                        | direction
// in       | in_valid, in_ready, in_item    | into block
// out      | out_valid, out_ready, out_item | out of block
// cfg      | psel..pready (apb)             | into block
//
// every item scans the table one entry a cycle through one key comparator fed by
// a registered key read, and the block takes no new item until it is through with the last.
// a record item that ends a batch then takes the batch count modulo the interval one bit
// at a time; a sweep reads and checks every entry and waits on out_ready for each
// evicted key after the first; a full-table retry scans the table once more.
// rst clears control state and all valid bits; no clearing pass needed.
// the block holds in_ready low while an item is at work or a result is stalled.
`include "assert_macros.svh"

module feature_admit_evict_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  faet_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output faet_pkg::out_item_t out_item,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import faet_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // configuration registers
  logic admit_enable;
  logic [31:0] admit_threshold;
  logic [31:0] evict_age;
  logic [15:0] evict_interval;

  // table storage
  logic [63:0] entry_key [TABLE_DEPTH];
  logic [39:0] entry_count [TABLE_DEPTH];
  logic [31:0] entry_stamp [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] count_valid;
  logic [TABLE_DEPTH-1:0] stamp_valid;
  logic [31:0] latest_stamp;
  logic [31:0] batch_counter;

  // sequencer
  state_t state, state_next;
  in_item_t cur;
  logic [CW-1:0] idx;
  logic hit_found, free_found, sweep_pending, full_flag;
  logic [IW-1:0] hit_idx, free_idx;
  logic [63:0] rd_key;
  logic [39:0] rd_count;
  logic [31:0] rd_stamp;
  logic out_is_filter_pending;
  logic cmp_live;
  logic [IW-1:0] cmp_idx;
  logic evict_held;
  logic [63:0] held_key;
  logic [16:0] rem;
  logic [4:0] mod_bit;

  wire cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ADMIT_ENABLE: prdata = {31'd0, admit_enable};
      REG_ADMIT_THRESHOLD: prdata = admit_threshold;
      REG_EVICT_AGE: prdata = evict_age;
      REG_EVICT_INTERVAL: prdata = {16'd0, evict_interval};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      admit_enable <= 1'b0;
      admit_threshold <= 32'd0;
      evict_age <= 32'd0;
      evict_interval <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ADMIT_ENABLE: admit_enable <= pwdata[0];
        REG_ADMIT_THRESHOLD: admit_threshold <= pwdata;
        REG_EVICT_AGE: evict_age <= pwdata;
        REG_EVICT_INTERVAL: evict_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  wire [IW-1:0] ix = idx[IW-1:0];
  wire occupied = count_valid[ix] | stamp_valid[ix];
  wire cmp_occ = count_valid[cmp_idx] | stamp_valid[cmp_idx];
  wire cmp_hit = cmp_live && cmp_occ && rd_key == cur.key;
  wire [IW-1:0] tgt = hit_found ? hit_idx : free_idx;
  wire tgt_ok = hit_found | free_found;
  wire [39:0] clamped = cur.count_value[31] ? 40'd0 : {8'd0, cur.count_value};
  wire [39:0] amt = cur.count_present ? clamped : 40'd1;
  wire [40:0] sum = {1'b0, (count_valid[tgt] ? rd_count : 40'd0)} + {1'b0, amt};
  wire [15:0] iv = (evict_interval == 16'd0) ? 16'd1 : evict_interval;
  wire [31:0] age = latest_stamp - rd_stamp;
  wire evict_hit = stamp_valid[ix] && latest_stamp > rd_stamp && age > evict_age;
  // restoring remainder of batch_counter + 1 by the interval, one bit a cycle
  wire [31:0] bc_next = batch_counter + 32'd1;
  wire [16:0] rem_shift = {rem[15:0], bc_next[mod_bit]};
  wire rem_ge = rem_shift >= {1'b0, iv};
  wire sweep_go = cur.batch_end && batch_counter != 32'd0 &&
                  rem == 17'd0 && evict_age != 32'd0;
  wire scan_done = (idx == DEPTH_C - CW'(1));

  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_next = ST_READ;
      ST_READ: begin
        if (cur.op == OP_RECORD && cur.batch_end) state_next = ST_MOD;
        else state_next = ST_APPLY;
      end
      ST_MOD: if (mod_bit == 5'd0) state_next = ST_APPLY;
      ST_APPLY: begin
        if (cur.op == OP_RECORD && sweep_go) state_next = ST_SWEEP_RD;
        else if (cur.op == OP_RECORD && !tgt_ok) state_next = ST_RETRY;
        else state_next = ST_EMIT;
      end
      ST_SWEEP_RD: state_next = ST_SWEEP_CHK;
      ST_SWEEP_CHK: begin
        if (evict_hit && evict_held) state_next = ST_SWEEP_OUT;
        else if (scan_done) state_next = sweep_pending ? ST_RETRY : ST_EMIT;
        else state_next = ST_SWEEP_RD;
      end
      ST_SWEEP_OUT: begin
        if (out_ready) begin
          if (scan_done) state_next = sweep_pending ? ST_RETRY : ST_EMIT;
          else state_next = ST_SWEEP_RD;
        end
      end
      ST_RETRY: if (scan_done) state_next = ST_EMIT;
      ST_EMIT: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready) state_next = (evict_held && full_flag) ? ST_OUT_WAIT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = 1'b0;
    out_item = '0;
    case (state)
      ST_SWEEP_OUT: begin
        out_valid = 1'b1;
        out_item.kind = KIND_EVICT;
        out_item.key_out = held_key;
      end
      ST_OUT_WAIT: begin
        out_valid = 1'b1;
        if (evict_held) begin
          // last evicted key closes the item unless a table-full result follows
          out_item.kind = KIND_EVICT;
          out_item.key_out = held_key;
          out_item.last = !full_flag;
        end else begin
          out_item.last = 1'b1;
          if (full_flag) out_item.kind = KIND_FULL;
          else if (out_is_filter_pending) begin
            out_item.kind = KIND_FILTER;
            out_item.rejected = sweep_pending;
            out_item.key_out = sweep_pending ? 64'd0 : cur.key;
          end else out_item.kind = KIND_ACK;
        end
      end
      default: ;
    endcase
  end

  // index and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
      sweep_pending <= 1'b0;
      full_flag <= 1'b0;
      out_is_filter_pending <= 1'b0;
      cmp_live <= 1'b0;
      evict_held <= 1'b0;
      rem <= '0;
      mod_bit <= 5'd31;
      count_valid <= '0;
      stamp_valid <= '0;
      latest_stamp <= 32'd0;
      batch_counter <= 32'd0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          hit_found <= 1'b0;
          free_found <= 1'b0;
          sweep_pending <= 1'b0;
          full_flag <= 1'b0;
          out_is_filter_pending <= 1'b0;
          cmp_live <= 1'b0;
          evict_held <= 1'b0;
          rem <= '0;
          mod_bit <= 5'd31;
        end
        ST_SCAN: begin
          // key compare runs one entry behind the registered key read
          if (cmp_hit && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx <= cmp_idx;
          end
          cmp_live <= 1'b1;
          if (!occupied && !free_found) begin
            free_found <= 1'b1;
            free_idx <= ix;
          end
          if (!scan_done) idx <= idx + CW'(1);
        end
        ST_SCAN_WAIT: begin
          if (cmp_hit && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx <= cmp_idx;
          end
        end
        ST_MOD: begin
          rem <= rem_ge ? rem_shift - {1'b0, iv} : rem_shift;
          mod_bit <= mod_bit - 5'd1;
        end
        ST_APPLY: begin
          idx <= '0;
          case (cur.op)
            OP_ADD: begin
              if (tgt_ok) begin
                count_valid[tgt] <= 1'b1;
                entry_count[tgt] <= sum[40] ? COUNT_MAX : sum[39:0];
              end else full_flag <= 1'b1;
            end
            OP_FILTER: begin
              out_is_filter_pending <= 1'b1;
              sweep_pending <= admit_enable && hit_found && count_valid[hit_idx] &&
                               rd_count < {8'd0, admit_threshold};
            end
            OP_RECORD: begin
              if (tgt_ok) begin
                stamp_valid[tgt] <= 1'b1;
                entry_stamp[tgt] <= cur.stamp;
              end else sweep_pending <= 1'b1;
              if (cur.stamp > latest_stamp) latest_stamp <= cur.stamp;
              if (cur.batch_end) batch_counter <= batch_counter + 32'd1;
            end
            OP_LOAD_COUNT: begin
              if (tgt_ok) begin
                count_valid[tgt] <= 1'b1;
                entry_count[tgt] <= clamped;
              end else full_flag <= 1'b1;
            end
            OP_LOAD_STAMP: begin
              if (tgt_ok) begin
                stamp_valid[tgt] <= 1'b1;
                if (!stamp_valid[tgt] || cur.stamp > rd_stamp)
                  entry_stamp[tgt] <= cur.stamp;
              end else full_flag <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_SWEEP_CHK: begin
          // the first evicted key is held back until the next result is known
          if (evict_hit && !evict_held) begin
            held_key <= rd_key;
            evict_held <= 1'b1;
            stamp_valid[ix] <= 1'b0;
            if (admit_enable) count_valid[ix] <= 1'b0;
          end
          if (!(evict_hit && evict_held)) idx <= scan_done ? '0 : idx + CW'(1);
        end
        ST_SWEEP_OUT: begin
          if (out_ready) begin
            held_key <= rd_key;
            stamp_valid[ix] <= 1'b0;
            if (admit_enable) count_valid[ix] <= 1'b0;
            idx <= scan_done ? '0 : idx + CW'(1);
          end
        end
        ST_RETRY: begin
          if (!occupied && !free_found) begin
            free_found <= 1'b1;
            stamp_valid[ix] <= 1'b1;
            entry_key[ix] <= cur.key;
            entry_stamp[ix] <= cur.stamp;
          end
          if (scan_done && !free_found && occupied) full_flag <= 1'b1;
          if (!scan_done) idx <= idx + CW'(1);
        end
        ST_OUT_WAIT: begin
          if (out_ready) evict_held <= 1'b0;
        end
        default: ;
      endcase
      if (state == ST_APPLY && cur.op != OP_FILTER && cur.op <= OP_LOAD_STAMP &&
          !hit_found && free_found)
        entry_key[free_idx] <= cur.key;
    end
  end

  // item capture and registered table reads
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) cur <= in_item;
    if (state == ST_SCAN) begin
      rd_key <= entry_key[ix];
      cmp_idx <= ix;
    end else if (state == ST_READ) begin
      rd_count <= entry_count[tgt];
      rd_stamp <= entry_stamp[tgt];
    end else if (state == ST_SWEEP_RD) begin
      rd_key <= entry_key[ix];
      rd_stamp <= entry_stamp[ix];
    end
  end

  `ASSERT_IMPL(a_out_only_busy, out_valid, !in_ready)
  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == ST_SCAN)
  `ASSERT_IMPL(a_evict_kind, state == ST_SWEEP_OUT, out_item.kind == KIND_EVICT && !out_item.last)

endmodule

FILE: verif/feature_admit_evict_table_test.sv
// self-checking testbench of the feature admit/evict table
// depends on faet_pkg and feature_admit_evict_table; predicts every result in place
`timescale 1ns / 1ps

module feature_admit_evict_table_test;
  import faet_pkg::*;

  localparam int DEPTH = 64;
  localparam int SETTLE = 600;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  feature_admit_evict_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow copy of the table and its settings
  logic [63:0] tab_key [DEPTH];
  logic [39:0] tab_count [DEPTH];
  bit tab_count_ok [DEPTH];
  logic [31:0] tab_stamp [DEPTH];
  bit tab_stamp_ok [DEPTH];
  logic [31:0] newest_stamp = '0;
  logic [31:0] batches_seen = '0;
  bit admit_on = 1'b0;
  logic [31:0] admit_min = '0;
  logic [31:0] max_age = '0;
  logic [15:0] sweep_every = 16'd1;

  out_item_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int evicted_seen = 0;
  int full_seen = 0;
  int filtered_seen = 0;
  bit steady_ready = 1'b0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tab_count_ok[i] = 0;
      tab_stamp_ok[i] = 0;
      tab_count[i] = '0;
      tab_stamp[i] = '0;
      tab_key[i] = '0;
    end
  end

  function automatic int lookup_key(logic [63:0] k);
    for (int i = 0; i < DEPTH; i++)
      if ((tab_count_ok[i] || tab_stamp_ok[i]) && tab_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int claim_slot(logic [63:0] k);
    for (int i = 0; i < DEPTH; i++)
      if (!tab_count_ok[i] && !tab_stamp_ok[i]) begin
        tab_key[i] = k;
        tab_count[i] = '0;
        tab_stamp[i] = '0;
        return i;
      end
    return -1;
  endfunction

  function automatic int lookup_or_claim(logic [63:0] k);
    int i;
    i = lookup_key(k);
    return (i >= 0) ? i : claim_slot(k);
  endfunction

  function automatic out_item_t make_result(logic [1:0] kind, logic [63:0] k, logic rej);
    out_item_t r;
    r.kind = kind;
    r.key_out = k;
    r.rejected = rej;
    r.last = 1'b0;
    return r;
  endfunction

  // works out the results of one accepted item and updates the shadow table
  function automatic void predict_table_op(in_item_t it);
    out_item_t res[$];
    logic [63:0] k;
    logic [40:0] amount;
    logic [40:0] total;
    logic [39:0] clamped;
    logic [31:0] iv;
    bit full;
    bit retry;
    bit rej;
    int i;
    k = it.key;
    clamped = it.count_value[31] ? 40'd0 : {8'd0, it.count_value};
    full = 0;
    retry = 0;
    case (it.op)
      OP_ADD: begin
        amount = it.count_present ? {1'b0, clamped} : 41'd1;
        i = lookup_or_claim(k);
        if (i < 0) full = 1;
        else begin
          if (!tab_count_ok[i]) begin
            tab_count[i] = '0;
            tab_count_ok[i] = 1;
          end
          total = {1'b0, tab_count[i]} + amount;
          tab_count[i] = (total > {1'b0, COUNT_MAX}) ? COUNT_MAX : total[39:0];
        end
      end
      OP_FILTER: begin
        i = lookup_key(k);
        rej = admit_on && i >= 0 && tab_count_ok[i] && tab_count[i] < {8'd0, admit_min};
        res.push_back(make_result(KIND_FILTER, rej ? 64'd0 : k, rej));
      end
      OP_RECORD: begin
        i = lookup_or_claim(k);
        if (i < 0) retry = 1;
        else begin
          tab_stamp[i] = it.stamp;
          tab_stamp_ok[i] = 1;
        end
        if (it.stamp > newest_stamp) newest_stamp = it.stamp;
        if (it.batch_end) begin
          iv = (sweep_every == 0) ? 32'd1 : {16'd0, sweep_every};
          if (batches_seen > 0 && (batches_seen + 32'd1) % iv == 0 && max_age != 0) begin
            // age sweep in entry order
            for (int j = 0; j < DEPTH; j++)
              if (tab_stamp_ok[j] && newest_stamp > tab_stamp[j] &&
                  newest_stamp - tab_stamp[j] > max_age) begin
                res.push_back(make_result(KIND_EVICT, tab_key[j], 1'b0));
                tab_stamp_ok[j] = 0;
                tab_stamp[j] = '0;
                if (admit_on) begin
                  tab_count_ok[j] = 0;
                  tab_count[j] = '0;
                end
              end
          end
          batches_seen = batches_seen + 32'd1;
        end
        if (retry) begin
          i = claim_slot(k);
          if (i < 0) full = 1;
          else begin
            tab_stamp[i] = it.stamp;
            tab_stamp_ok[i] = 1;
          end
        end
      end
      OP_LOAD_COUNT: begin
        i = lookup_or_claim(k);
        if (i < 0) full = 1;
        else begin
          tab_count[i] = clamped;
          tab_count_ok[i] = 1;
        end
      end
      OP_LOAD_STAMP: begin
        i = lookup_or_claim(k);
        if (i < 0) full = 1;
        else begin
          if (!tab_stamp_ok[i]) begin
            tab_stamp[i] = '0;
            tab_stamp_ok[i] = 1;
          end
          if (it.stamp > tab_stamp[i]) tab_stamp[i] = it.stamp;
        end
      end
      default: ;
    endcase
    if (full) res.push_back(make_result(KIND_FULL, 64'd0, 1'b0));
    if (res.size() == 0) res.push_back(make_result(KIND_ACK, 64'd0, 1'b0));
    res[res.size() - 1].last = 1'b1;
    foreach (res[n]) expected_results.push_back(res[n]);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d key %h",
                                  out_item.kind, out_item.key_out));
      end else begin
        want = expected_results.pop_front();
        if (out_item.kind == KIND_EVICT) evicted_seen++;
        if (out_item.kind == KIND_FULL) full_seen++;
        if (out_item.kind == KIND_FILTER && out_item.rejected) filtered_seen++;
        if (out_item.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, want.kind));
        if (out_item.key_out !== want.key_out)
          report_mismatch($sformatf("key_out %h, want %h", out_item.key_out, want.key_out));
        if (out_item.rejected !== want.rejected)
          report_mismatch($sformatf("rejected %b, want %b", out_item.rejected, want.rejected));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_item.last, want.last));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady_ready ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_item(logic [2:0] op, logic [63:0] k, logic [31:0] cv, logic cp,
                           logic [31:0] st, logic be);
    in_item_t it;
    it.op = op;
    it.key = k;
    it.count_value = cv;
    it.count_present = cp;
    it.stamp = st;
    it.batch_end = be;
    if (!steady_ready)
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_table_op(it);
    items_sent++;
    in_valid <= 1'b0;
    // the block stays busy after an accept until the item is done
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ADMIT_ENABLE: admit_on = value[0];
      REG_ADMIT_THRESHOLD: admit_min = value;
      REG_EVICT_AGE: max_age = value;
      default: sweep_every = value[15:0];
    endcase
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic en, logic [31:0] thr, logic [31:0] age, logic [15:0] iv);
    wait_drained();
    write_reg(REG_ADMIT_ENABLE, {31'd0, en});
    write_reg(REG_ADMIT_THRESHOLD, thr);
    write_reg(REG_EVICT_AGE, age);
    write_reg(REG_EVICT_INTERVAL, {16'd0, iv});
  endtask

  // field extremes, every op and unknown ops, default settings first
  task automatic test_basic_ops();
    send_item(OP_FILTER, 64'h8000_0000_0000_0000, 32'h0, 1'b0, 32'h0, 1'b0);
    send_item(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
    send_item(OP_ADD, 64'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    send_item(OP_LOAD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
    send_item(OP_LOAD_STAMP, 64'h8000_0000_0000_0000, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_LOAD_STAMP, 64'h8000_0000_0000_0000, 32'h0, 1'b0, 32'h10, 1'b0);
    send_item(OP_RECORD, 64'h1, 32'h0, 1'b0, 32'h100, 1'b1);
    send_item(3'd5, 64'h5, 32'h5, 1'b1, 32'h5, 1'b1);
    send_item(3'd6, 64'h6, 32'h6, 1'b0, 32'h6, 1'b0);
    send_item(3'd7, 64'h7, 32'h7, 1'b1, 32'h7, 1'b1);
  endtask

  // filter under admission: unknown, below and at threshold
  task automatic test_admission();
    set_config(1'b1, 32'd10, 32'd0, 16'd1);
    send_item(OP_FILTER, 64'h1234, 32'h0, 1'b0, 32'h0, 1'b0);
    send_item(OP_ADD, 64'h1234, 32'd9, 1'b1, 32'h0, 1'b0);
    send_item(OP_FILTER, 64'h1234, 32'h0, 1'b0, 32'h0, 1'b0);
    send_item(OP_ADD, 64'h1234, 32'h0, 1'b0, 32'h0, 1'b0);
    send_item(OP_FILTER, 64'h1234, 32'h0, 1'b0, 32'h0, 1'b0);
    send_item(OP_FILTER, 64'h1, 32'h0, 1'b0, 32'h0, 1'b0);
    set_config(1'b1, 32'hFFFF_FFFF, 32'd0, 16'd1);
    send_item(OP_FILTER, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0);
  endtask

  // sweeps, future stamps kept, then a full table with a retried record
  task automatic test_eviction_and_full();
    set_config(1'b1, 32'd0, 32'd50, 16'd1);
    send_item(OP_RECORD, 64'hA, 32'h0, 1'b0, 32'd1000, 1'b0);
    send_item(OP_LOAD_STAMP, 64'hB, 32'h0, 1'b0, 32'd5000, 1'b0);
    send_item(OP_RECORD, 64'hC, 32'h0, 1'b0, 32'd2000, 1'b1);
    send_item(OP_RECORD, 64'hC, 32'h0, 1'b0, 32'd2000, 1'b1);
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_LOAD_COUNT, 64'h100 + i, $urandom, 1'b1, 32'h0, 1'b0);
    send_item(OP_ADD, 64'hDEAD, 32'd1, 1'b1, 32'h0, 1'b0);
    send_item(OP_LOAD_COUNT, 64'hDEAD, 32'd1, 1'b1, 32'h0, 1'b0);
    send_item(OP_LOAD_STAMP, 64'hDEAD, 32'd1, 1'b1, 32'd7, 1'b0);
    send_item(OP_RECORD, 64'hDEAD, 32'h0, 1'b0, 32'd2100, 1'b0);
    send_item(OP_RECORD, 64'hDEAD, 32'h0, 1'b0, 32'd2100, 1'b1);
    send_item(OP_RECORD, 64'hBEEF, 32'h0, 1'b0, 32'd9000, 1'b1);
  endtask

  // random well-formed traffic on a key pool, with fresh keys and noise
  task automatic run_random(int count, int pool_size);
    logic [63:0] pool [64];
    logic [31:0] clock_stamp;
    logic [63:0] k;
    logic [31:0] cv;
    logic [31:0] st;
    logic [2:0] op;
    int pick;
    clock_stamp = newest_stamp;
    for (int i = 0; i < 64; i++) pool[i] = {$urandom, $urandom};
    pool[0] = 64'h8000_0000_0000_0000;
    pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      k = (pick < 85) ? pool[$urandom_range(0, pool_size - 1)] : {$urandom, $urandom};
      cv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
      clock_stamp = clock_stamp + $urandom_range(0, 30);
      st = ($urandom_range(0, 19) == 0) ? $urandom : clock_stamp - $urandom_range(0, 200);
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_RECORD;
      else if (pick < 55) op = OP_ADD;
      else if (pick < 75) op = OP_FILTER;
      else if (pick < 85) op = OP_LOAD_COUNT;
      else if (pick < 95) op = OP_LOAD_STAMP;
      else op = 3'($urandom_range(5, 7));
      send_item(op, k, cv, 1'($urandom_range(0, 1)), st, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_admission();
    test_eviction_and_full();
    set_config(1'b1, 32'd30, 32'd400, 16'd2);
    run_random(110, 40);
    set_config(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    steady_ready = 1'b1;
    run_random(80, 64);
    steady_ready = 1'b0;
    set_config(1'b1, 32'd0, 32'd60, 16'd1);
    run_random(170, 48);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("run: %0d items, %0d results (%0d evicted, %0d table full, %0d rejected)",
             items_sent, results_seen, evicted_seen, full_seen, filtered_seen);
    $display("covered all ops, unknown ops, admission, age sweeps and full-table retry");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
